// File: design/osc_pkg.sv
package osc_pkg;

  localparam int SampleBitsDefault = 24;
  localparam int CoefBits  = 24;
  localparam int GainBits  = 24;
  localparam int ThrBits   = 23;
  localparam int StateBits = 32;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 24;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_PRE_GAIN   = 3'd0,
    REG_CLIP_THR   = 3'd1,
    REG_HPF_IN     = 3'd2,
    REG_HPF_FB     = 3'd3,
    REG_LPF_FWD    = 3'd4,
    REG_LPF_FB1    = 3'd5,
    REG_LPF_FB2    = 3'd6
  } reg_idx_t;

  // Control of the serial multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctl_t;

endpackage

// File: design/osc_stream_if.sv
interface osc_stream_if #(
  parameter int W = 24
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/osc_serial_mac.sv
// Bit-serial signed multiply-accumulate: acc += a * b, one bit of the
// multiplier a per cycle (shift-and-add, LSB first).
module osc_serial_mac
  import osc_pkg::*;
#(
  parameter int AW = 33,
  parameter int BW = 32,
  parameter int ACCW = 72
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mac_ctl_t               ctl,
  input  logic signed [AW-1:0]   a,
  input  logic signed [BW-1:0]   b,
  output logic                   busy,
  output logic signed [ACCW-1:0] acc
);
  localparam int CW = $clog2(AW + 1);

  logic [AW-1:0]          a_r;
  logic signed [ACCW-1:0] b_r;
  logic signed [ACCW-1:0] acc_r;
  logic [CW-1:0]          cnt_r;
  logic                   busy_r;
  logic signed [ACCW-1:0] addend;

  // The sign bit of a carries negative weight.
  assign addend = (cnt_r == CW'(1)) ? -b_r : b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(AW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (busy_r && a_r[0]) begin
      acc_r <= acc_r + addend;
    end
    if (ctl.start) begin
      a_r <= a;
      b_r <= ACCW'(b);
    end else if (busy_r) begin
      a_r <= a_r >> 1;
      b_r <= b_r <<< 1;
    end
  end

  assign busy = busy_r | ctl.start;
  assign acc  = acc_r;
endmodule

// File: design/overdrive_soft_clip_filter.sv
// Overdrive soft clipper: high-pass, pre-gain, symmetric soft clip, second-order
// low-pass, clamp. One sample at a time. Each product runs on one shared
// bit-serial multiply-accumulate unit, with a start state, the serial steps and a
// done check. There are six products a sample, or seven in the soft region,
// since the square adds a product there, and the soft region also takes a
// divide-by-three step. The result waits in an output register while the
// next sample is accepted. A result that is still waiting when the next one is
// done stalls the block until the receiver takes it. Filter history clears at
// reset.
module overdrive_soft_clip_filter
  import osc_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst_n,
  osc_stream_if.sink             in_s,
  osc_stream_if.source           out_s,
  input  logic                   cfg_we,
  input  logic [CfgIdxBits-1:0]  cfg_idx,
  input  logic [CfgDataBits-1:0] cfg_data
);
  localparam int F    = SAMPLE_BITS - 1;
  localparam int AW   = 35;
  localparam int BW   = 36;
  localparam int ACCW = 72;
  localparam int DW   = 2 * F + 12;
  localparam int DCW  = $clog2(DW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_WAIT, S_HPF, S_GAIN, S_CLIP, S_DIV, S_SOFT, S_LPF, S_OUT
  } st_t;

  logic [GainBits-1:0]        pre_gain_r;
  logic [ThrBits-1:0]         thr_r;
  logic signed [CoefBits-1:0] hg_r, hf_r, la_r, l1_r, l2_r;

  logic signed [SAMPLE_BITS-1:0] x_r, hpf_prev_in_r, lpf_in_one_r, lpf_in_two_r;
  logic signed [StateBits-1:0]   hpf_prev_out_r, lpf_out_one_r, lpf_out_two_r;
  logic signed [SAMPLE_BITS-1:0] co_r, out_r;
  logic                          out_v_r;
  logic signed [41:0]            c_r;
  logic                          neg_r;
  logic [35:0]                   mag_r;

  st_t       st_r;
  logic [2:0] step_r;
  logic [2:0] nsteps_r;
  st_t       after_r;

  logic signed [AW-1:0] ma;
  logic signed [BW-1:0] mb;
  mac_ctl_t             mctl;
  logic                 mbusy;
  logic signed [ACCW-1:0] macc;

  // Serial divider for (sq+1)/3, restoring, one quotient bit a cycle.
  logic [DW-1:0]  dnum_r;
  logic [2:0]     drem_r;
  logic [DCW-1:0] dcnt_r;
  logic [3:0]     dtry;

  // The unit starts in S_MUL and clears only for the first product of a phase.
  assign mctl.start = (st_r == S_MUL);
  assign mctl.clear = (st_r == S_MUL) && (step_r == 3'd0);

  osc_serial_mac #(.AW(AW), .BW(BW), .ACCW(ACCW)) u_mac (
    .clk(clk), .rst_n(rst_n), .ctl(mctl), .a(ma), .b(mb), .busy(mbusy), .acc(macc)
  );

  function automatic logic signed [ACCW-1:0] rnd(input logic signed [ACCW-1:0] v,
                                                 input int s);
    logic signed [ACCW-1:0] t;
    t = v + (ACCW'(1) <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic logic signed [StateBits-1:0] sat32(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] hi, lo;
    hi = ACCW'(32'sh7fffffff);
    lo = -hi - ACCW'(1);
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[StateBits-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] satn(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] hi, lo;
    hi = (ACCW'(1) <<< (SAMPLE_BITS - 1)) - ACCW'(1);
    lo = -hi - ACCW'(1);
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    if (v < lo) return lo[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Operand selection for each product of the current phase.
  always_comb begin
    ma = '0;
    mb = '0;
    case (after_r)
      S_HPF: begin
        if (step_r == 3'd0) begin
          ma = AW'(hg_r);
          mb = BW'(x_r) - BW'(hpf_prev_in_r);
        end else begin
          ma = AW'(hf_r);
          mb = BW'(hpf_prev_out_r);
        end
      end
      S_GAIN: begin
        ma = AW'(signed'({1'b0, pre_gain_r}));
        mb = BW'(hpf_prev_out_r);
      end
      S_SOFT: begin
        ma = AW'(signed'({1'b0, mag_r[33:0]}));
        mb = BW'(signed'({1'b0, mag_r[33:0]}));
      end
      S_LPF: begin
        case (step_r)
          3'd0: begin
            ma = AW'(la_r);
            mb = BW'(co_r) + (BW'(lpf_in_one_r) <<< 1) + BW'(lpf_in_two_r);
          end
          3'd1: begin
            ma = AW'(l1_r);
            mb = BW'(lpf_out_one_r);
          end
          default: begin
            ma = AW'(l2_r);
            mb = BW'(lpf_out_two_r);
          end
        endcase
      end
      default: ;
    endcase
  end

  logic [ACCW-1:0] thr_f, a_abs;
  logic signed [ACCW-1:0] hy_w, c_w, ly_w, sq_w;
  assign thr_f = ACCW'(({{(ACCW-ThrBits){1'b0}}, thr_r} << F) >> 23);
  assign a_abs = neg_r ? ACCW'(-ACCW'(c_r)) : ACCW'(c_r);
  assign hy_w  = ACCW'(sat32(rnd(macc, 22)));
  assign c_w   = rnd(macc, 16);
  assign ly_w  = ACCW'(sat32(rnd(macc, 22)));
  assign sq_w  = macc >>> F;
  assign dtry  = {drem_r, dnum_r[DW-1]};

  assign in_s.ready = (st_r == S_IDLE);
  assign out_s.valid = out_v_r;
  assign out_s.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_gain_r <= 24'd65536;
      thr_r      <= 23'd2796203;
      hg_r       <= 24'sd4140116;
      hf_r       <= 24'sd4085928;
      la_r       <= 24'sd180560;
      l1_r       <= 24'sd4907592;
      l2_r       <= -24'sd1435590;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_PRE_GAIN: pre_gain_r <= cfg_data;
        REG_CLIP_THR: thr_r      <= cfg_data[ThrBits-1:0];
        REG_HPF_IN:   hg_r       <= cfg_data;
        REG_HPF_FB:   hf_r       <= cfg_data;
        REG_LPF_FWD:  la_r       <= cfg_data;
        REG_LPF_FB1:  l1_r       <= cfg_data;
        REG_LPF_FB2:  l2_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= S_IDLE;
      out_v_r        <= 1'b0;
      hpf_prev_in_r  <= '0;
      hpf_prev_out_r <= '0;
      lpf_in_one_r   <= '0;
      lpf_in_two_r   <= '0;
      lpf_out_one_r  <= '0;
      lpf_out_two_r  <= '0;
      step_r         <= '0;
      nsteps_r       <= '0;
      after_r        <= S_IDLE;
    end else begin
      if (out_v_r && out_s.ready && st_r != S_OUT) begin
        out_v_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_s.valid) begin
            x_r      <= in_s.data;
            after_r  <= S_HPF;
            nsteps_r <= 3'd2;
            step_r   <= '0;
            st_r     <= S_MUL;
          end
        end
        S_MUL: begin
          st_r <= S_WAIT;
        end
        S_WAIT: begin
          if (!mbusy) begin
            if (step_r + 3'd1 < nsteps_r) begin
              step_r <= step_r + 3'd1;
              st_r   <= S_MUL;
            end else begin
              st_r <= after_r;
            end
          end
        end
        S_HPF: begin
          hpf_prev_in_r  <= x_r;
          hpf_prev_out_r <= hy_w[StateBits-1:0];
          after_r  <= S_GAIN;
          nsteps_r <= 3'd1;
          step_r   <= '0;
          st_r     <= S_MUL;
        end
        S_GAIN: begin
          c_r   <= c_w[41:0];
          neg_r <= c_w[ACCW-1];
          st_r  <= S_CLIP;
        end
        S_CLIP: begin
          if (a_abs < thr_f) begin
            co_r <= satn(ACCW'(c_r) <<< 1);
            after_r <= S_LPF;
            nsteps_r <= 3'd3;
            step_r <= '0;
            st_r <= S_MUL;
          end else if (a_abs < (thr_f << 1)) begin
            // |2 - 3a| at fraction F, then square on the serial unit.
            if ((ACCW'(1) << (F + 1)) >= a_abs * 3)
              mag_r <= 36'((ACCW'(1) << (F + 1)) - a_abs * 3);
            else
              mag_r <= 36'(a_abs * 3 - (ACCW'(1) << (F + 1)));
            after_r  <= S_SOFT;
            nsteps_r <= 3'd1;
            step_r   <= '0;
            st_r     <= S_MUL;
          end else begin
            co_r <= satn(neg_r ? -ACCW'(thr_f << 1) : ACCW'(thr_f << 1));
            after_r <= S_LPF;
            nsteps_r <= 3'd3;
            step_r <= '0;
            st_r <= S_MUL;
          end
        end
        S_SOFT: begin
          dnum_r <= DW'(sq_w + ACCW'(1));
          drem_r <= '0;
          dcnt_r <= DCW'(DW);
          st_r   <= S_DIV;
        end
        S_DIV: begin
          if (dcnt_r == '0) begin
            co_r <= satn(neg_r ? -((ACCW'(1) << F) - ACCW'(dnum_r))
                               : ((ACCW'(1) << F) - ACCW'(dnum_r)));
            after_r  <= S_LPF;
            nsteps_r <= 3'd3;
            step_r   <= '0;
            st_r     <= S_MUL;
          end else begin
            dcnt_r <= dcnt_r - DCW'(1);
            if (dtry >= 4'd3) begin
              drem_r <= 3'(dtry - 4'd3);
              dnum_r <= {dnum_r[DW-2:0], 1'b1};
            end else begin
              drem_r <= dtry[2:0];
              dnum_r <= {dnum_r[DW-2:0], 1'b0};
            end
          end
        end
        S_LPF: begin
          lpf_in_two_r  <= lpf_in_one_r;
          lpf_in_one_r  <= co_r;
          lpf_out_two_r <= lpf_out_one_r;
          lpf_out_one_r <= ly_w[StateBits-1:0];
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_v_r || out_s.ready) begin
            out_r   <= satn(ACCW'(lpf_out_one_r));
            out_v_r <= 1'b1;
            st_r    <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
